>>> sv/ocsa_pkg.sv
// Shared constants, codes and types of the overflow chunk slot allocator.
`default_nettype none
package ocsa_pkg;

  localparam int SLOTS = 16;
  localparam int PAGE_BYTES = 4096;
  localparam int HEADER_BYTES = 96;

  localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW = $clog2(SLOTS + 1);
  localparam int MaxBytes = (PAGE_BYTES > HEADER_BYTES) ? PAGE_BYTES : HEADER_BYTES;
  localparam int ByteW = $clog2(MaxBytes + 1);
  localparam int SizeW = 13;
  localparam int FieldW = 13;
  localparam int SumW = ((ByteW > SizeW) ? ByteW : SizeW) + 1;
  localparam int FreeReset = (PAGE_BYTES > HEADER_BYTES) ? PAGE_BYTES - HEADER_BYTES : 0;

  localparam int InDataW = 24;
  localparam int OutDataW = 48;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_VACUUM = 2'd2;

  localparam logic [1:0] STS_OK = 2'd0;
  localparam logic [1:0] STS_NO_SPACE = 2'd1;
  localparam logic [1:0] STS_RANGE = 2'd2;
  localparam logic [1:0] STS_UNUSED = 2'd3;

  typedef struct packed {
    logic [FieldW-1:0] old_offset;
    logic [FieldW-1:0] length;
    logic [FieldW-1:0] offset;
    logic [3:0]        slot;
    logic [1:0]        status;
  } res_t;

  function automatic logic [3:0] slot_field(input logic [SlotW-1:0] s);
    logic [7:0] wide;
    wide = 8'(s);
    return wide[3:0];
  endfunction

endpackage
`default_nettype wire

>>> sv/overflow_chunk_slot_allocator_top.sv
// Top level of the overflow chunk slot allocator: slot table, sequencer and result register.
//
//  Channel | Dir | Handshake            | Payload
//  s_axis  | in  | tvalid / tready      | tdata: cmd, chunk_size, slot_index
//  m_axis  | out | tvalid / tready      | tdata: status, slot, offset, length, old_offset; tlast
//
// In allocate, one shared adder and a slot pointer walk the used marks one slot per cycle; vacuum
// walks them one slot per cycle through the same adder, holding on a used slot while the result
// register is full and not taken, and then hands over the summary transaction.
// A new command is accepted only in the idle state; a finished result may still wait downstream.
// The sequencer holds whenever it has a result to hand over and a full result register stalls.
// Reset is asynchronous and needs no clearing pass; offsets and lengths are written before use.
`default_nettype none
module overflow_chunk_slot_allocator_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [1:0] cmd, [14:2] chunk_size, [22:15] slot_index, [23] zero
  input  wire logic [ocsa_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [1:0] status, [5:2] slot, [18:6] offset, [31:19] length, [44:32] old_offset, [47:45] zero
  output logic [ocsa_pkg::OutDataW-1:0]      m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);
  import ocsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_SCAN,
    S_READ,
    S_VAC,
    S_SUM
  } state_e;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(SLOTS - 1);

  state_e               state_q, state_d;
  logic [SlotW-1:0]     cnt_q, cnt_d;
  logic [SLOTS-1:0]     used_q, used_d;
  logic [ByteW-1:0]     bump_q, bump_d;
  logic [ByteW-1:0]     free_q, free_d;
  logic [ByteW-1:0]     pay_q, pay_d;
  logic [CntW-1:0]      ucnt_q, ucnt_d;
  logic [CntW-1:0]      fcnt_q, fcnt_d;
  logic                 oval_q, oval_d;
  logic                 olast_q, olast_d;

  logic [1:0]           cmd_q, cmd_d;
  logic [SizeW-1:0]     size_q, size_d;
  logic [7:0]           idx_q, idx_d;
  logic [ByteW-1:0]     next_q, next_d;
  logic [CntW-1:0]      vused_q, vused_d;
  res_t                 res_q, res_d;

  logic [ByteW-1:0]     slot_off_q [SLOTS];
  logic [ByteW-1:0]     slot_len_q [SLOTS];

  logic [1:0]           in_cmd;
  logic [SizeW-1:0]     in_size;
  logic [7:0]           in_idx;
  logic [SlotW-1:0]     rd_addr;
  logic [ByteW-1:0]     rd_off;
  logic [ByteW-1:0]     rd_len;
  logic [SumW-1:0]      op_a;
  logic [SumW-1:0]      op_b;
  logic [SumW-1:0]      sum;
  logic                 can_emit;
  logic                 off_we;
  logic                 len_we;
  logic [ByteW-1:0]     wr_off;
  logic [ByteW-1:0]     wr_len;
  logic                 rd_bad;

  assign in_cmd  = s_axis_tdata_i[1:0];
  assign in_size = s_axis_tdata_i[14:2];
  assign in_idx  = s_axis_tdata_i[22:15];

  assign rd_addr = (state_q == S_READ) ? SlotW'(idx_q) : cnt_q;
  assign rd_off  = slot_off_q[rd_addr];
  assign rd_len  = slot_len_q[rd_addr];
  assign rd_bad  = idx_q >= 8'(SLOTS);

  assign op_a = (state_q == S_SCAN) ? SumW'(bump_q) : SumW'(next_q);
  assign op_b = (state_q == S_SCAN) ? SumW'(size_q) : SumW'(rd_len);
  assign sum  = op_a + op_b;

  assign can_emit = !oval_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    used_d  = used_q;
    bump_d  = bump_q;
    free_d  = free_q;
    pay_d   = pay_q;
    ucnt_d  = ucnt_q;
    fcnt_d  = fcnt_q;
    cmd_d   = cmd_q;
    size_d  = size_q;
    idx_d   = idx_q;
    next_d  = next_q;
    vused_d = vused_q;
    res_d   = res_q;
    olast_d = olast_q;
    oval_d  = oval_q && !m_axis_tready_i;
    off_we  = 1'b0;
    len_we  = 1'b0;
    wr_off  = rd_off;
    wr_len  = rd_len;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d   = in_cmd;
          size_d  = in_size;
          idx_d   = in_idx;
          cnt_d   = '0;
          next_d  = ByteW'(HEADER_BYTES);
          vused_d = '0;
          case (in_cmd)
            CMD_ALLOC: begin
              if ((SumW'(in_size) > SumW'(free_q)) || (ucnt_q >= CntW'(SLOTS))) begin
                state_d = S_ERR;
              end else begin
                state_d = S_SCAN;
              end
            end
            CMD_READ:   state_d = S_READ;
            CMD_VACUUM: state_d = S_VAC;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_ERR: begin
        if (can_emit) begin
          res_d         = '0;
          res_d.status  = STS_NO_SPACE;
          olast_d       = 1'b1;
          oval_d        = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!used_q[cnt_q]) begin
          if (can_emit) begin
            res_d   = '0;
            olast_d = 1'b1;
            oval_d  = 1'b1;
            state_d = S_IDLE;
            if (sum > SumW'(PAGE_BYTES)) begin
              res_d.status = STS_NO_SPACE;
            end else begin
              used_d[cnt_q] = 1'b1;
              off_we        = 1'b1;
              len_we        = 1'b1;
              wr_off        = bump_q;
              wr_len        = ByteW'(size_q);
              bump_d        = ByteW'(sum);
              free_d        = ByteW'(SumW'(free_q) - SumW'(size_q));
              pay_d         = ByteW'(SumW'(pay_q) + SumW'(size_q));
              ucnt_d        = ucnt_q + CntW'(1);
              fcnt_d        = (fcnt_q != '0) ? fcnt_q - CntW'(1) : '0;
              res_d.status  = STS_OK;
              res_d.slot    = slot_field(cnt_q);
              res_d.offset  = FieldW'(bump_q);
              res_d.length  = FieldW'(size_q);
            end
          end
        end else if (cnt_q == LastSlot) begin
          state_d = S_ERR;
        end else begin
          cnt_d = cnt_q + SlotW'(1);
        end
      end
      S_READ: begin
        if (can_emit) begin
          res_d   = '0;
          olast_d = 1'b1;
          oval_d  = 1'b1;
          state_d = S_IDLE;
          if (rd_bad) begin
            res_d.status = STS_RANGE;
          end else if (!used_q[rd_addr]) begin
            res_d.status = STS_UNUSED;
          end else begin
            res_d.status = STS_OK;
            res_d.slot   = slot_field(rd_addr);
            res_d.offset = FieldW'(rd_off);
            res_d.length = FieldW'(rd_len);
          end
        end
      end
      S_VAC: begin
        if (!used_q[cnt_q] || can_emit) begin
          if (used_q[cnt_q]) begin
            off_we           = 1'b1;
            wr_off           = next_q;
            next_d           = ByteW'(sum);
            vused_d          = vused_q + CntW'(1);
            res_d.status     = STS_OK;
            res_d.slot       = slot_field(cnt_q);
            res_d.offset     = FieldW'(next_q);
            res_d.length     = FieldW'(rd_len);
            res_d.old_offset = FieldW'(rd_off);
            olast_d          = 1'b0;
            oval_d           = 1'b1;
          end
          if (cnt_q == LastSlot) begin
            state_d = S_SUM;
          end else begin
            cnt_d = cnt_q + SlotW'(1);
          end
        end
      end
      S_SUM: begin
        if (can_emit) begin
          bump_d       = next_q;
          free_d       = (SumW'(next_q) < SumW'(PAGE_BYTES))
                         ? ByteW'(SumW'(PAGE_BYTES) - SumW'(next_q)) : '0;
          pay_d        = ByteW'(SumW'(next_q) - SumW'(HEADER_BYTES));
          ucnt_d       = vused_q;
          fcnt_d       = CntW'(SLOTS) - vused_q;
          res_d        = '0;
          res_d.status = STS_OK;
          res_d.offset = FieldW'(next_q);
          res_d.length = FieldW'(SumW'(next_q) - SumW'(HEADER_BYTES));
          olast_d      = 1'b1;
          oval_d       = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      used_q  <= '0;
      bump_q  <= ByteW'(HEADER_BYTES);
      free_q  <= ByteW'(FreeReset);
      pay_q   <= '0;
      ucnt_q  <= '0;
      fcnt_q  <= CntW'(SLOTS);
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      used_q  <= used_d;
      bump_q  <= bump_d;
      free_q  <= free_d;
      pay_q   <= pay_d;
      ucnt_q  <= ucnt_d;
      fcnt_q  <= fcnt_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    size_q  <= size_d;
    idx_q   <= idx_d;
    next_q  <= next_d;
    vused_q <= vused_d;
    res_q   <= res_d;
    olast_q <= olast_d;
    if (off_we) begin
      slot_off_q[cnt_q] <= wr_off;
    end
    if (len_we) begin
      slot_len_q[cnt_q] <= wr_len;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = oval_q;
  assign m_axis_tdata_o  = OutDataW'(res_q);
  assign m_axis_tlast_o  = olast_q;

endmodule
`default_nettype wire

>>> sv/ocsa_checker.sv
// Port-level checker of the overflow chunk slot allocator and its bind to the top level.
`default_nettype none
module ocsa_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid_i,
  input wire logic                          s_axis_tready_o,
  input wire logic [ocsa_pkg::InDataW-1:0]  s_axis_tdata_i,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i,
  input wire logic [ocsa_pkg::OutDataW-1:0] m_axis_tdata_o,
  input wire logic                          m_axis_tlast_o
);
  import ocsa_pkg::*;

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // Any error status ends the run of results of its command.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[1:0] != STS_OK) |-> m_axis_tlast_o)
    else $error("error result without tlast");

  // Error results carry no location.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[1:0] != STS_OK) |->
      (m_axis_tdata_o[44:2] == '0))
    else $error("error result with nonzero fields");

  // A valid command keeps the input closed in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o &&
      (s_axis_tdata_i[1:0] == CMD_ALLOC || s_axis_tdata_i[1:0] == CMD_READ ||
       s_axis_tdata_i[1:0] == CMD_VACUUM) |=> !s_axis_tready_o)
    else $error("input accepted while a command is in progress");

endmodule

bind overflow_chunk_slot_allocator_top ocsa_checker u_ocsa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
`default_nettype wire

>>> tb/tb_overflow_chunk_slot_allocator_top.sv
// Self-checking testbench of the overflow chunk slot allocator top level.
`default_nettype none
module tb_overflow_chunk_slot_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ocsa_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int StallLimit = 2000;
  localparam int ItemsPerPhase = 62;

  typedef struct {
    res_t res;
    logic last;
  } chunk_result_t;

  class page_ledger;
    bit                slot_busy[SLOTS];
    logic [FieldW-1:0] slot_start[SLOTS];
    logic [FieldW-1:0] slot_bytes[SLOTS];
    logic [FieldW-1:0] bump;
    logic [FieldW-1:0] spare_bytes;
    int unsigned       busy_count;
    int unsigned       mismatches;
    chunk_result_t     pending_results[$];

    function new();
      foreach (slot_busy[i]) begin
        slot_busy[i] = 1'b0;
        slot_start[i] = '0;
        slot_bytes[i] = '0;
      end
      bump = FieldW'(HEADER_BYTES);
      spare_bytes = FieldW'(FreeReset);
      busy_count = 0;
      mismatches = 0;
    endfunction

    function void queue_result(logic [1:0] status, int slot, int offset, int length,
                               int old_offset, logic last);
      chunk_result_t r;
      r.res.status = status;
      r.res.slot = 4'(slot);
      r.res.offset = FieldW'(offset);
      r.res.length = FieldW'(length);
      r.res.old_offset = FieldW'(old_offset);
      r.last = last;
      pending_results.push_back(r);
    endfunction

    function void note_command(logic [1:0] cmd, logic [SizeW-1:0] size, logic [7:0] idx);
      int slot;
      int place;
      int total;
      int busy;
      case (cmd)
        CMD_ALLOC: begin
          slot = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (!slot_busy[i] && slot < 0) slot = i;
          end
          if (int'(size) > int'(spare_bytes) || busy_count >= SLOTS || slot < 0 ||
              int'(bump) + int'(size) > PAGE_BYTES) begin
            queue_result(STS_NO_SPACE, 0, 0, 0, 0, 1'b1);
          end else begin
            slot_busy[slot] = 1'b1;
            slot_start[slot] = bump;
            slot_bytes[slot] = size;
            queue_result(STS_OK, slot, bump, size, 0, 1'b1);
            bump = bump + size;
            spare_bytes = spare_bytes - size;
            busy_count++;
          end
        end
        CMD_READ: begin
          if (idx >= SLOTS) begin
            queue_result(STS_RANGE, 0, 0, 0, 0, 1'b1);
          end else if (!slot_busy[idx]) begin
            queue_result(STS_UNUSED, 0, 0, 0, 0, 1'b1);
          end else begin
            queue_result(STS_OK, idx, slot_start[idx], slot_bytes[idx], 0, 1'b1);
          end
        end
        CMD_VACUUM: begin
          place = HEADER_BYTES;
          total = 0;
          busy = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_busy[i]) begin
              queue_result(STS_OK, i, place, slot_bytes[i], slot_start[i], 1'b0);
              slot_start[i] = FieldW'(place);
              place += slot_bytes[i];
              total += slot_bytes[i];
              busy++;
            end
          end
          bump = FieldW'(place);
          spare_bytes = (PAGE_BYTES > place) ? FieldW'(PAGE_BYTES - place) : '0;
          busy_count = busy;
          queue_result(STS_OK, 0, place, total, 0, 1'b1);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(logic [OutDataW-1:0] data, logic last);
      res_t got;
      chunk_result_t want;
      got = res_t'(data[$bits(res_t)-1:0]);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: status %0d slot %0d offset %0d length %0d old %0d last %0d",
                   got.status, got.slot, got.offset, got.length, got.old_offset, last);
        end
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.res.status || got.slot !== want.res.slot ||
          got.offset !== want.res.offset || got.length !== want.res.length ||
          got.old_offset !== want.res.old_offset || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("expected status %0d slot %0d offset %0d length %0d old %0d last %0d",
                   want.res.status, want.res.slot, want.res.offset, want.res.length,
                   want.res.old_offset, want.last);
          $display("got      status %0d slot %0d offset %0d length %0d old %0d last %0d",
                   got.status, got.slot, got.offset, got.length, got.old_offset, last);
        end
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tlast_o;

  int unsigned send_idle = 15;
  int unsigned recv_idle = 79;
  int unsigned quiet_cycles = 0;
  page_ledger  ledger;

  overflow_chunk_slot_allocator_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      ledger.check_result(m_axis_tdata_o, m_axis_tlast_o);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= StallLimit) begin
      $display("tb_overflow_chunk_slot_allocator_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_command(logic [1:0] cmd, logic [SizeW-1:0] size, logic [7:0] idx);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {1'b0, idx, size, cmd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    ledger.note_command(cmd, size, idx);
  endtask

  initial begin
    int unsigned      issued;
    int unsigned      pick;
    int unsigned      sel;
    logic [1:0]       cmd;
    logic [SizeW-1:0] size;
    logic [7:0]       idx;

    ledger = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_command(CMD_READ, 13'd0, 8'd0);
    send_command(CMD_VACUUM, 13'd0, 8'd0);
    send_command(CMD_ALLOC, 13'd0, 8'd0);
    send_command(CMD_ALLOC, 13'd4096, 8'd0);
    send_command(CMD_ALLOC, 13'd4001, 8'd0);
    send_command(CMD_ALLOC, 13'd100, 8'd0);
    send_command(CMD_READ, 13'd0, 8'd0);
    send_command(CMD_READ, 13'd0, 8'd1);
    send_command(CMD_READ, 13'd0, 8'd2);
    send_command(CMD_READ, 13'd0, 8'd15);
    send_command(CMD_READ, 13'd0, 8'd16);
    send_command(CMD_READ, 13'd0, 8'd255);
    send_command(CMD_READ, 13'd0, 8'd128);
    send_command(CMD_UNKNOWN, 13'd4095, 8'd170);
    send_command(CMD_VACUUM, 13'd0, 8'd0);
    send_command(CMD_ALLOC, 13'd4095, 8'd0);
    send_command(CMD_ALLOC, 13'd3899, 8'd255);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 15 : (phase == 1) ? 79 : 0;
      recv_idle = (phase == 0) ? 79 : (phase == 1) ? 15 : 0;
      issued = 0;
      while (issued < ItemsPerPhase) begin
        pick = $urandom_range(0, 99);
        size = SizeW'($urandom_range(0, 4096));
        idx = 8'($urandom_range(0, 255));
        if (pick < 38) begin
          cmd = CMD_ALLOC;
          sel = $urandom_range(0, 15);
          if (sel == 0) begin
            size = '0;
          end else if (sel < 9) begin
            size = SizeW'($urandom_range(1, 200));
          end else if (sel == 9 && ledger.busy_count >= SLOTS - 2) begin
            size = ledger.spare_bytes;
          end else if (sel == 10 && ledger.spare_bytes < PAGE_BYTES) begin
            size = ledger.spare_bytes + 1'b1;
          end
        end else if (pick < 78) begin
          cmd = CMD_READ;
          if ($urandom_range(0, 3) != 0) idx = 8'($urandom_range(0, SLOTS - 1));
        end else if (pick < 93) begin
          cmd = CMD_VACUUM;
        end else begin
          cmd = CMD_UNKNOWN;
        end
        send_command(cmd, size, idx);
        if (cmd != CMD_UNKNOWN) issued++;
      end
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (ledger.pending_results.size() != 0) @(posedge clk_i);
    repeat (4 * SLOTS) @(posedge clk_i);

    if (ledger.mismatches == 0 && ledger.pending_results.size() == 0) begin
      $display("tb_overflow_chunk_slot_allocator_top passed");
    end else begin
      $display("tb_overflow_chunk_slot_allocator_top failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
sv/ocsa_pkg.sv
sv/overflow_chunk_slot_allocator_top.sv
sv/ocsa_checker.sv
tb/tb_overflow_chunk_slot_allocator_top.sv
